// ----- rtl/ber_tlv_stream_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// BER TLV stream decoder: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_STREAM_DECODER_CORE_DEFINES_SVH
`define BER_TLV_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTLV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BTLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/btlv_pkg.sv -----
// ----------------------------------------------------------------------------
// btlv_pkg
// Result record, result kinds and error codes of the BER TLV stream decoder.
// ----------------------------------------------------------------------------
package btlv_pkg;

    // Result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [1:0] ERR_EARLY    = 2'd2;

    // Length octet: long form flag and count mask
    localparam logic [7:0] LONG_FORM_FLAG = 8'h80;
    localparam logic [7:0] LENGTH_MASK    = 8'h7F;

    // One result as delivered on the output channel
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  elem_tag;
        logic [31:0] elem_length;
        logic [7:0]  value_byte;
        logic        element_last;
        logic        all_done;
        logic [1:0]  error_code;
    } result_t;

endpackage

// ----- rtl/ber_tlv_stream_decoder_core.sv -----
// A result is registered into the result register, or into the skid entry on a stall.
// One byte per cycle while in_ready is high; parser state updates on each transfer.
// A two-entry output buffer (result register plus skid) keeps in_ready independent of
// out_ready; in_ready drops only while the skid entry is occupied.
// Reset (rst_n low, asynchronous): parser back to expecting a tag, buffers empty,
// element_count set to 1.
// ----------------------------------------------------------------------------
// ber_tlv_stream_decoder_core
// BER definite-length TLV stream decoder with registered, buffered results.
// ----------------------------------------------------------------------------
module ber_tlv_stream_decoder_core #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        stream_last,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  elem_tag,
    output logic [31:0] elem_length,
    output logic [7:0]  value_byte,
    output logic        element_last,
    output logic        all_done,
    output logic [1:0]  error_code
);

    logic [7:0]        element_count_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    btlv_pkg::result_t out_data_reg;
    btlv_pkg::result_t skid_data_reg;

    logic              accept;
    logic              pop;
    logic              emit;
    btlv_pkg::result_t result;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    btlv_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .stream_last   (stream_last),
        .element_count (element_count_reg),
        .emit          (emit),
        .result        (result)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            element_count_reg <= 8'd1;
        else if (cfg_wr_en)
            element_count_reg <= cfg_wr_data;
    end

    // Output buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (accept && emit)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= result;
            else
                out_data_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_data_reg.result_kind;
    assign elem_tag     = out_data_reg.elem_tag;
    assign elem_length  = out_data_reg.elem_length;
    assign value_byte   = out_data_reg.value_byte;
    assign element_last = out_data_reg.element_last;
    assign all_done     = out_data_reg.all_done;
    assign error_code   = out_data_reg.error_code;

endmodule

// ----- rtl/btlv_parser.sv -----
// ----------------------------------------------------------------------------
// btlv_parser
// Header/value parsing state; one byte per transfer, at most one result.
// ----------------------------------------------------------------------------
module btlv_parser #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               stream_last,
    input  logic [7:0]         element_count,
    output logic               emit,
    output btlv_pkg::result_t  result
);

    localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

    // Phase codes
    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LONG    = 3'd2;
    localparam logic [2:0] PH_VALUE   = 3'd3;
    localparam logic [2:0] PH_DISCARD = 3'd4;

    logic [2:0]        phase_reg,      phase_next;
    logic [7:0]        tag_reg,        tag_next;
    logic [31:0]       acc_reg,        acc_next;
    logic [LEFT_W-1:0] len_left_reg,   len_left_next;
    logic [31:0]       val_left_reg,   val_left_next;
    logic [7:0]        elem_done_reg,  elem_done_next;

    logic       header;
    logic       complete;
    logic       done;
    logic [6:0] count_field;
    logic [1:0] kind;
    logic [1:0] err;
    logic [7:0] vbyte;
    logic       elast;

    assign count_field = data_byte[6:0] & btlv_pkg::LENGTH_MASK[6:0];

    // Next state and result for the byte on the input
    always_comb
    begin
        phase_next     = phase_reg;
        tag_next       = tag_reg;
        acc_next       = acc_reg;
        len_left_next  = len_left_reg;
        val_left_next  = val_left_reg;
        elem_done_next = elem_done_reg;
        emit           = 1'b0;
        header         = 1'b0;
        complete       = 1'b0;
        done           = 1'b0;
        kind           = btlv_pkg::KIND_ERROR;
        err            = btlv_pkg::ERR_NONE;
        vbyte          = 8'd0;
        elast          = 1'b0;

        if (phase_reg != PH_DISCARD)
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    tag_next   = data_byte;
                    acc_next   = 32'd0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if ((data_byte & btlv_pkg::LONG_FORM_FLAG) != 8'd0)
                    begin
                        if (count_field > 7'(MAX_LENGTH_BYTES))
                        begin
                            err        = btlv_pkg::ERR_TOO_MANY;
                            emit       = 1'b1;
                            phase_next = PH_DISCARD;
                        end
                        else if (count_field == 7'd0)
                        begin
                            acc_next = 32'd0;
                            header   = 1'b1;
                        end
                        else
                        begin
                            len_left_next = count_field[LEFT_W-1:0];
                            phase_next    = PH_LONG;
                        end
                    end
                    else
                    begin
                        acc_next = {25'd0, count_field};
                        header   = 1'b1;
                    end
                end
                PH_LONG:
                begin
                    acc_next      = {acc_reg[23:0], data_byte};
                    len_left_next = len_left_reg - LEFT_W'(1);
                    header        = (len_left_next == '0);
                end
                PH_VALUE:
                begin
                    emit          = 1'b1;
                    kind          = btlv_pkg::KIND_VALUE;
                    vbyte         = data_byte;
                    val_left_next = val_left_reg - 32'd1;
                    complete      = (val_left_next == 32'd0);
                end
                default:
                begin
                    phase_next = PH_DISCARD;
                end
            endcase

            // Header complete: report it, load the value count
            if (header)
            begin
                emit          = 1'b1;
                kind          = btlv_pkg::KIND_HEADER;
                val_left_next = acc_next;
                if (acc_next == 32'd0)
                    complete = 1'b1;
                else
                    phase_next = PH_VALUE;
            end

            // Element complete: count it, stop after the configured number
            if (complete)
            begin
                elast          = 1'b1;
                elem_done_next = elem_done_reg + 8'd1;
                if (elem_done_next == element_count)
                begin
                    done       = 1'b1;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    phase_next = PH_TAG;
                end
            end

            // Stream ended before the last element was complete
            if (stream_last && !done && err == btlv_pkg::ERR_NONE)
            begin
                err  = btlv_pkg::ERR_EARLY;
                emit = 1'b1;
            end
        end

        // End of buffer: start afresh
        if (stream_last)
        begin
            phase_next     = PH_TAG;
            tag_next       = 8'd0;
            acc_next       = 32'd0;
            len_left_next  = '0;
            val_left_next  = 32'd0;
            elem_done_next = 8'd0;
        end

        result.result_kind  = kind;
        result.elem_tag     = tag_next;
        result.elem_length  = acc_next;
        result.value_byte   = vbyte;
        result.element_last = elast;
        result.all_done     = done;
        result.error_code   = err;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            tag_reg       <= 8'd0;
            acc_reg       <= 32'd0;
            len_left_reg  <= '0;
            val_left_reg  <= 32'd0;
            elem_done_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            acc_reg       <= acc_next;
            len_left_reg  <= len_left_next;
            val_left_reg  <= val_left_next;
            elem_done_reg <= elem_done_next;
        end
    end

endmodule

// ----- rtl/btlv_checker.sv -----
// ----------------------------------------------------------------------------
// btlv_checker
// Port-level checks on the result channel of the BER TLV stream decoder.
// ----------------------------------------------------------------------------
`include "ber_tlv_stream_decoder_core_defines.svh"

module btlv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [7:0]  elem_tag,
    input logic [31:0] elem_length,
    input logic [7:0]  value_byte,
    input logic        element_last,
    input logic        all_done,
    input logic [1:0]  error_code
);

    // stalled result holds
    `BTLV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(elem_tag) && $stable(elem_length) && $stable(value_byte) && $stable(error_code), "stalled result changed")

    // value byte only carried by value results
    `BTLV_ASSERT_SAME(a_vbyte_zero, out_valid && result_kind != btlv_pkg::KIND_VALUE, value_byte == 8'd0, "value_byte set on non-value result")

    // buffer completion always closes an element cleanly
    `BTLV_ASSERT_SAME(a_done_last, out_valid && all_done, element_last && error_code == btlv_pkg::ERR_NONE, "all_done without clean element end")

    // error-only results carry an error
    `BTLV_ASSERT_SAME(a_err_kind, out_valid && result_kind == btlv_pkg::KIND_ERROR, error_code != btlv_pkg::ERR_NONE, "error result without error code")

    // length overflow is reported only as an error-only result
    `BTLV_ASSERT_SAME(a_too_many, out_valid && error_code == btlv_pkg::ERR_TOO_MANY, result_kind == btlv_pkg::KIND_ERROR && !element_last, "length overflow on wrong result kind")

endmodule

bind ber_tlv_stream_decoder_core btlv_checker u_btlv_checker (.*);
